@@ rtl/psic_pkg.sv @@
// Shared request codes, status codes and interface structs for the polygon checker.
package psic_pkg;

   localparam int IN_BITS  = 16;
   localparam int VCOUNT_W = 7;

   localparam logic [1:0] REQ_START  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_MOVE   = 2'd2;
   localparam logic [1:0] REQ_REMOVE = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_NO_POLY = 2'd2;
   localparam logic [1:0] STATUS_FEW     = 2'd3;

   localparam int MOVE_SCAN_MIN = 3;
   localparam int REMOVE_MIN    = 2;

   typedef struct packed {
      logic vld;
      logic first;
      logic scan;
   } psic_vtx_ctrl_type;

   typedef struct packed {
      logic busy;
      logic hit;
   } psic_edge_stat_type;

endpackage

@@ rtl/psic_edge_test.sv @@
// Pipelined crossing test of streamed polygon edges against segment a-b0 or a-b1, chosen by scan.
module psic_edge_test
   import psic_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  psic_vtx_ctrl_type              ctrl,
   input  logic signed [COORD_BITS-1:0]   vx,
   input  logic signed [COORD_BITS-1:0]   vy,
   input  logic signed [COORD_BITS-1:0]   ax,
   input  logic signed [COORD_BITS-1:0]   ay,
   input  logic signed [COORD_BITS-1:0]   b0x,
   input  logic signed [COORD_BITS-1:0]   b0y,
   input  logic signed [COORD_BITS-1:0]   b1x,
   input  logic signed [COORD_BITS-1:0]   b1y,
   output psic_edge_stat_type             stat
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;

   function automatic logic signed [DW-1:0] sub(input logic signed [COORD_BITS-1:0] a,
                                                input logic signed [COORD_BITS-1:0] b);
      return DW'(a) - DW'(b);
   endfunction

   function automatic logic signed [PW-1:0] smul(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
      return PW'(a) * PW'(b);
   endfunction

   // {negative, positive}
   function automatic logic [1:0] sgn2(input logic signed [PW-1:0] p,
                                       input logic signed [PW-1:0] q);
      logic signed [SW-1:0] d;
      d = SW'(p) - SW'(q);
      return {d[SW-1], (d != '0) && !d[SW-1]};
   endfunction

   function automatic logic overlap(input logic signed [COORD_BITS-1:0] a,
                                    input logic signed [COORD_BITS-1:0] b,
                                    input logic signed [COORD_BITS-1:0] c,
                                    input logic signed [COORD_BITS-1:0] d);
      logic signed [COORD_BITS-1:0] lo1, hi1, lo2, hi2;
      lo1 = (a > b) ? b : a;
      hi1 = (a > b) ? a : b;
      lo2 = (c > d) ? d : c;
      hi2 = (c > d) ? c : d;
      return (lo1 <= hi2) && (lo2 <= hi1);
   endfunction

   logic signed [COORD_BITS-1:0] cx_ff, cy_ff;
   logic signed [COORD_BITS-1:0] bx, by;

   logic                 e_vld_ff;
   logic                 e_ovl_ff;
   logic signed [DW-1:0] e_bax_ff, e_bay_ff, e_cay_ff, e_cax_ff, e_day_ff, e_dax_ff;
   logic signed [DW-1:0] e_dcx_ff, e_dcy_ff, e_acy_ff, e_acx_ff, e_bcy_ff, e_bcx_ff;

   logic                 m_vld_ff;
   logic                 m_ovl_ff;
   logic signed [PW-1:0] m_p1_ff, m_p2_ff, m_p3_ff, m_p4_ff;
   logic signed [PW-1:0] m_p5_ff, m_p6_ff, m_p7_ff, m_p8_ff;

   logic [1:0] s_c, s_d, s_a, s_b;

   assign bx = ctrl.scan ? b1x : b0x;
   assign by = ctrl.scan ? b1y : b0y;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
         m_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= ctrl.vld && !ctrl.first;
         m_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.vld) begin
         cx_ff <= vx;
         cy_ff <= vy;
      end
      e_ovl_ff <= overlap(ax, bx, cx_ff, vx) && overlap(ay, by, cy_ff, vy);
      e_bax_ff <= sub(bx, ax);
      e_bay_ff <= sub(by, ay);
      e_cay_ff <= sub(cy_ff, ay);
      e_cax_ff <= sub(cx_ff, ax);
      e_day_ff <= sub(vy, ay);
      e_dax_ff <= sub(vx, ax);
      e_dcx_ff <= sub(vx, cx_ff);
      e_dcy_ff <= sub(vy, cy_ff);
      e_acy_ff <= sub(ay, cy_ff);
      e_acx_ff <= sub(ax, cx_ff);
      e_bcy_ff <= sub(by, cy_ff);
      e_bcx_ff <= sub(bx, cx_ff);

      m_ovl_ff <= e_ovl_ff;
      m_p1_ff  <= smul(e_bax_ff, e_cay_ff);
      m_p2_ff  <= smul(e_bay_ff, e_cax_ff);
      m_p3_ff  <= smul(e_bax_ff, e_day_ff);
      m_p4_ff  <= smul(e_bay_ff, e_dax_ff);
      m_p5_ff  <= smul(e_dcx_ff, e_acy_ff);
      m_p6_ff  <= smul(e_dcy_ff, e_acx_ff);
      m_p7_ff  <= smul(e_dcx_ff, e_bcy_ff);
      m_p8_ff  <= smul(e_dcy_ff, e_bcx_ff);
   end

   assign s_c = sgn2(m_p1_ff, m_p2_ff);
   assign s_d = sgn2(m_p3_ff, m_p4_ff);
   assign s_a = sgn2(m_p5_ff, m_p6_ff);
   assign s_b = sgn2(m_p7_ff, m_p8_ff);

   assign stat.busy = e_vld_ff || m_vld_ff;
   assign stat.hit  = m_vld_ff && m_ovl_ff
                      && !((s_c[0] && s_d[0]) || (s_c[1] && s_d[1]))
                      && !((s_a[0] && s_b[0]) || (s_a[1] && s_b[1]));

endmodule

@@ rtl/polygon_self_intersection_check_core.sv @@
// Polygon vertex store with self-intersection check on moves of the last point.
//
// Requests arrive on req_ (valid/stall): start, append, move last, remove before last,
// with a signed point. Each request yields one response on rsp_ (valid/stall) with the
// crossing flag, the vertex count after the request and a status code.
// One request is handled at a time; req_stall is high while a request is in work.
// Start, append, error and short moves go from acceptance straight to the response state;
// remove passes through a read-modify-write state first. A move on more than three vertices
// streams the vertex memory twice through the crossing pipeline, one vertex per cycle on
// the single read port.
// The response sits in an output register; a stalled response holds and the next
// request is still accepted, though its own response waits for the register to free.
// Reset empties the polygon; the vertex memory is not cleared and needs no sweep.
module polygon_self_intersection_check_core
   import psic_pkg::*;
#(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_type,
   input  logic signed [IN_BITS-1:0]   req_point_x,
   input  logic signed [IN_BITS-1:0]   req_point_y,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_self_intersecting,
   output logic [VCOUNT_W-1:0]         rsp_vertex_count,
   output logic [1:0]                  rsp_status
);

   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int ADDR_W = $clog2(MAX_VERTICES);
   localparam int VW     = 2 * COORD_BITS;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RMW, ST_Q1, ST_S1, ST_S2, ST_DRAIN, ST_DONE
   } state_type;

   typedef enum logic [1:0] {RK_NONE, RK_Q0, RK_Q1, RK_VTX} rd_kind_type;

   state_type   state_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [ADDR_W-1:0] idx_ff, lim1_ff, lim2_ff, last_addr;
   logic        first_ff;
   logic        hit_ff;
   logic [1:0]  status_ff;
   logic [VW-1:0] p_ff, q0_ff, q1_ff;

   logic        rsp_valid_ff, rsp_hit_ff;
   logic [VCOUNT_W-1:0] rsp_count_ff;
   logic [1:0]  rsp_status_ff;

   logic [VW-1:0] vmem [MAX_VERTICES];
   logic [VW-1:0] rd_data_ff;
   rd_kind_type   rd_kind_ff;
   logic          rd_first_ff, rd_scan_ff;

   logic          wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [VW-1:0] wr_data;
   rd_kind_type   rd_kind;
   logic          rd_first, rd_scan;

   logic signed [31:0] px_wide, py_wide;
   logic [VW-1:0]      pt;
   logic [31:0]        count_wide;

   logic accept, has_poly, can_append, scan_move, can_remove;

   psic_vtx_ctrl_type  vtx_ctrl;
   psic_edge_stat_type edge_stat;

   assign px_wide    = 32'(req_point_x);
   assign py_wide    = 32'(req_point_y);
   assign pt         = {py_wide[COORD_BITS-1:0], px_wide[COORD_BITS-1:0]};
   assign count_wide = 32'(count_ff);

   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && (state_ff == ST_IDLE);
   assign has_poly   = (count_ff != '0);
   assign can_append = (count_ff < CNT_W'(MAX_VERTICES));
   assign scan_move  = (count_ff > CNT_W'(MOVE_SCAN_MIN));
   assign can_remove = (count_ff > CNT_W'(REMOVE_MIN));
   assign last_addr  = ADDR_W'(count_ff - CNT_W'(1));

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = pt;
      rd_en    = 1'b0;
      rd_addr  = '0;
      rd_kind  = RK_NONE;
      rd_first = 1'b0;
      rd_scan  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority if (req_type == REQ_START) begin
                  wr_en = 1'b1;
               end else if (!has_poly) begin
                  wr_en = 1'b0;
               end else if (req_type == REQ_APPEND) begin
                  wr_en   = can_append;
                  wr_addr = ADDR_W'(count_ff);
               end else if (req_type == REQ_MOVE) begin
                  wr_en   = 1'b1;
                  wr_addr = last_addr;
                  rd_en   = scan_move;
                  rd_kind = scan_move ? RK_Q0 : RK_NONE;
               end else begin
                  rd_en   = can_remove;
                  rd_addr = last_addr;
               end
            end
         end
         ST_RMW: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(count_ff - CNT_W'(REMOVE_MIN));
            wr_data = rd_data_ff;
         end
         ST_Q1: begin
            rd_en   = 1'b1;
            rd_addr = lim1_ff;
            rd_kind = RK_Q1;
         end
         ST_S1, ST_S2: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            rd_kind  = RK_VTX;
            rd_first = first_ff;
            rd_scan  = (state_ff == ST_S2);
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vmem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= vmem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_kind_ff <= RK_NONE;
      end else begin
         rd_kind_ff <= rd_kind;
      end
      rd_first_ff <= rd_first;
      rd_scan_ff  <= rd_scan;
      if (rd_kind_ff == RK_Q0) begin
         q0_ff <= rd_data_ff;
      end
      if (rd_kind_ff == RK_Q1) begin
         q1_ff <= rd_data_ff;
      end
   end

   assign vtx_ctrl.vld   = (rd_kind_ff == RK_VTX);
   assign vtx_ctrl.first = rd_first_ff;
   assign vtx_ctrl.scan  = rd_scan_ff;

   psic_edge_test #(
      .COORD_BITS (COORD_BITS)
   ) u_edge (
      .clock (clock),
      .reset (reset),
      .ctrl  (vtx_ctrl),
      .vx    (rd_data_ff[COORD_BITS-1:0]),
      .vy    (rd_data_ff[VW-1:COORD_BITS]),
      .ax    (p_ff[COORD_BITS-1:0]),
      .ay    (p_ff[VW-1:COORD_BITS]),
      .b0x   (q0_ff[COORD_BITS-1:0]),
      .b0y   (q0_ff[VW-1:COORD_BITS]),
      .b1x   (q1_ff[COORD_BITS-1:0]),
      .b1y   (q1_ff[VW-1:COORD_BITS]),
      .stat  (edge_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (edge_stat.hit) begin
            hit_ff <= 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  hit_ff    <= 1'b0;
                  status_ff <= STATUS_OK;
                  state_ff  <= ST_DONE;
                  priority if (req_type == REQ_START) begin
                     count_ff <= CNT_W'(1);
                  end else if (!has_poly) begin
                     status_ff <= STATUS_NO_POLY;
                  end else if (req_type == REQ_APPEND) begin
                     if (can_append) begin
                        count_ff <= count_ff + CNT_W'(1);
                     end else begin
                        status_ff <= STATUS_FULL;
                     end
                  end else if (req_type == REQ_MOVE) begin
                     p_ff     <= pt;
                     idx_ff   <= ADDR_W'(1);
                     first_ff <= 1'b1;
                     lim1_ff  <= ADDR_W'(count_ff - CNT_W'(REMOVE_MIN));
                     lim2_ff  <= ADDR_W'(count_ff - CNT_W'(MOVE_SCAN_MIN));
                     if (scan_move) begin
                        state_ff <= ST_Q1;
                     end
                  end else begin
                     if (can_remove) begin
                        state_ff <= ST_RMW;
                     end else begin
                        status_ff <= STATUS_FEW;
                     end
                  end
               end
            end
            ST_RMW: begin
               count_ff <= count_ff - CNT_W'(1);
               state_ff <= ST_DONE;
            end
            ST_Q1: begin
               state_ff <= ST_S1;
            end
            ST_S1: begin
               if (idx_ff == lim1_ff) begin
                  idx_ff   <= '0;
                  first_ff <= 1'b1;
                  state_ff <= ST_S2;
               end else begin
                  idx_ff   <= idx_ff + ADDR_W'(1);
                  first_ff <= 1'b0;
               end
            end
            ST_S2: begin
               if (idx_ff == lim2_ff) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  idx_ff   <= idx_ff + ADDR_W'(1);
                  first_ff <= 1'b0;
               end
            end
            ST_DRAIN: begin
               if ((rd_kind_ff != RK_VTX) && !edge_stat.busy) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_hit_ff    <= hit_ff;
                  rsp_count_ff  <= count_wide[VCOUNT_W-1:0];
                  rsp_status_ff <= status_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_self_intersecting = rsp_hit_ff;
   assign rsp_vertex_count      = rsp_count_ff;
   assign rsp_status            = rsp_status_ff;

endmodule
